/* src/lph_pkg.sv */
`default_nettype none
package lph_pkg;

	localparam int HASH_W  = 32;
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int SLOT_W  = 8;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;

	localparam int DEF_CAPACITY   = 256;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_VALUE_BITS = 32;

	typedef logic [1:0] mark_t;

	localparam mark_t MARK_EMPTY = 2'd0;
	localparam mark_t MARK_OCC   = 2'd1;
	localparam mark_t MARK_TOMB  = 2'd2;

	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS    = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STAT_W-1:0] ST_UPDATED = 2'd3;

	typedef struct packed {
		logic  mark_we;
		mark_t mark_d;
		logic  key_we;
		logic  val_we;
	} wr_ctl_t;

endpackage
`default_nettype wire

/* src/lph_home.sv */
`default_nettype none
module lph_home #(
	parameter int CAPACITY = lph_pkg::DEF_CAPACITY
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [lph_pkg::HASH_W-1:0]        hash,
	output logic                                   done,
	output logic [$clog2(CAPACITY)-1:0]            home
);
	import lph_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	generate
		if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_pow2
			logic          done_q;
			logic [AW-1:0] home_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					home_q <= hash[AW-1:0];
				end
			end

			assign done = done_q;
			assign home = home_q;
		end else begin : g_div
			localparam int QW = HASH_W - AW + 1;
			localparam logic [HASH_W:0] RECIP =
				(HASH_W+1)'((64'd1 << (HASH_W + AW)) / 64'(CAPACITY));
			localparam logic [AW:0] CAP_W = (AW+1)'(CAPACITY);

			logic [3:0]          step_q;
			logic [HASH_W-1:0]   hash_q;
			logic [QW-1:0]       quo_q;
			logic [AW:0]         rem_q;
			logic [AW-1:0]       home_q;
			logic [2*HASH_W:0]   prod;
			logic [AW:0]         quo_cap;
			logic [AW:0]         rem_fix;

			// reciprocal multiply gives the quotient or one less; one subtract fixes it
			assign prod    = hash_q * RECIP;
			assign quo_cap = (AW+1)'(quo_q) * CAP_W;
			assign rem_fix = (rem_q >= CAP_W) ? rem_q - CAP_W : rem_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					step_q <= '0;
				end else begin
					step_q <= {step_q[2:0], start};
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					hash_q <= hash;
				end
				if (step_q[0]) begin
					quo_q <= prod[2*HASH_W:HASH_W+AW];
				end
				if (step_q[1]) begin
					rem_q <= hash_q[AW:0] - quo_cap;
				end
				if (step_q[2]) begin
					home_q <= rem_fix[AW-1:0];
				end
			end

			assign done = step_q[3];
			assign home = home_q;
		end
	endgenerate

endmodule
`default_nettype wire

/* src/lph_store.sv */
`default_nettype none
module lph_store #(
	parameter int CAPACITY   = lph_pkg::DEF_CAPACITY,
	parameter int KEY_BITS   = lph_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = lph_pkg::DEF_VALUE_BITS
) (
	input  wire logic                        clk,
	input  wire lph_pkg::wr_ctl_t            wr,
	input  wire logic [$clog2(CAPACITY)-1:0] wr_addr,
	input  wire logic [KEY_BITS-1:0]         key_d,
	input  wire logic [VALUE_BITS-1:0]       val_d,
	input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
	output lph_pkg::mark_t                   mark_rd,
	output logic [KEY_BITS-1:0]              key_rd,
	output logic [VALUE_BITS-1:0]            val_rd
);
	import lph_pkg::*;

	mark_t                 mark_mem [CAPACITY];
	logic [KEY_BITS-1:0]   key_mem  [CAPACITY];
	logic [VALUE_BITS-1:0] val_mem  [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.mark_we) begin
			mark_mem[wr_addr] <= wr.mark_d;
		end
		mark_rd <= mark_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr_addr] <= key_d;
		end
		key_rd <= key_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.val_we) begin
			val_mem[wr_addr] <= val_d;
		end
		val_rd <= val_mem[rd_addr];
	end

endmodule
`default_nettype wire

/* src/linear_probe_hash_table_core.sv */
// channel   dir  handshake            words
// request   in   start && !busy       mode, key, entry_value, hash
// result    out  done (one cycle)     status, found_value, slot
//
// Request: loaded when accepted; the home slot is then registered from the low hash
// bits (CAPACITY a power of two) or from a reciprocal multiply and one correction;
// slots are then probed in turn through the registered store read port, and the
// result is registered so that it shows in the cycle after the last probe.
// After reset busy stays high while the marks of all slots are swept empty.
// Results cannot be stalled; a new request may be taken while done is high.
`default_nettype none
module linear_probe_hash_table_core #(
	parameter int CAPACITY   = lph_pkg::DEF_CAPACITY,
	parameter int KEY_BITS   = lph_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = lph_pkg::DEF_VALUE_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [lph_pkg::MODE_W-1:0]    mode,
	input  wire logic [lph_pkg::KEY_W-1:0]     key,
	input  wire logic [lph_pkg::VALUE_W-1:0]   entry_value,
	input  wire logic [lph_pkg::HASH_W-1:0]    hash,
	output logic                               done,
	output logic [lph_pkg::STAT_W-1:0]         status,
	output logic [lph_pkg::VALUE_W-1:0]        found_value,
	output logic [lph_pkg::SLOT_W-1:0]         slot
);
	import lph_pkg::*;

	localparam int          AW         = $clog2(CAPACITY);
	localparam logic [AW:0] FILL_LIMIT = (AW+1)'(CAPACITY * 3 / 4);
	localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

	localparam logic [1:0] S_CLR   = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_HOME  = 2'd2;
	localparam logic [1:0] S_PROBE = 2'd3;

	logic [1:0]            state_q;
	logic [AW-1:0]         clr_q;
	logic [AW:0]           cnt_q;
	logic [MODE_W-1:0]     mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         n_q;
	logic                  tomb_v_q;
	logic [AW-1:0]         tomb_idx_q;

	logic                  done_q;
	logic [STAT_W-1:0]     status_q;
	logic [VALUE_W-1:0]    fval_q;
	logic [SLOT_W-1:0]     slot_q;

	logic                  accept;
	logic                  home_done;
	logic [AW-1:0]         home;
	mark_t                 mark_rd;
	logic [KEY_BITS-1:0]   key_rd;
	logic [VALUE_BITS-1:0] val_rd;

	wr_ctl_t               wr;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         idx_nx;
	logic                  hit;
	logic                  fin;
	logic                  probing;
	logic                  cnt_inc;
	logic                  cnt_dec;
	logic [STAT_W-1:0]     res_status;
	logic [VALUE_W-1:0]    res_fval;
	logic [AW-1:0]         res_idx;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign probing = (state_q == S_PROBE);
	assign idx_nx  = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign hit     = (mark_rd == MARK_OCC) && (key_rd == key_q);
	assign fin     = hit || (mark_rd == MARK_EMPTY) || (n_q == LAST_IDX);

	lph_home #(
		.CAPACITY(CAPACITY)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.hash  (hash),
		.done  (home_done),
		.home  (home)
	);

	lph_store #(
		.CAPACITY  (CAPACITY),
		.KEY_BITS  (KEY_BITS),
		.VALUE_BITS(VALUE_BITS)
	) u_store (
		.clk    (clk),
		.wr     (wr),
		.wr_addr(wr_addr),
		.key_d  (key_q),
		.val_d  (val_q),
		.rd_addr(rd_addr),
		.mark_rd(mark_rd),
		.key_rd (key_rd),
		.val_rd (val_rd)
	);

	// read address, end-of-probe decision and store writes
	always_comb begin
		wr         = '0;
		wr_addr    = idx_q;
		rd_addr    = idx_q;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		res_status = ST_MISS;
		res_fval   = '0;
		res_idx    = '0;
		unique case (state_q)
			S_CLR: begin
				wr.mark_we = 1'b1;
				wr.mark_d  = MARK_EMPTY;
				wr_addr    = clr_q;
			end
			S_HOME: begin
				rd_addr = home;
			end
			S_PROBE: begin
				if (!fin) begin
					rd_addr = idx_nx;
				end else if (hit) begin
					unique case (mode_q)
						MODE_LOOKUP: begin
							res_status = ST_OK;
							res_fval   = VALUE_W'(val_rd);
							res_idx    = idx_q;
						end
						MODE_INSERT: begin
							wr.val_we  = 1'b1;
							res_status = ST_UPDATED;
							res_idx    = idx_q;
						end
						MODE_REMOVE: begin
							wr.mark_we = 1'b1;
							wr.mark_d  = MARK_TOMB;
							cnt_dec    = (cnt_q != '0);
							res_status = ST_OK;
							res_idx    = idx_q;
						end
						default: begin
							res_status = ST_MISS;
						end
					endcase
				end else if (mode_q == MODE_INSERT) begin
					priority if (cnt_q >= FILL_LIMIT) begin
						res_status = ST_FULL;
					end else if (tomb_v_q || (mark_rd != MARK_OCC)) begin
						wr_addr    = tomb_v_q ? tomb_idx_q : idx_q;
						wr.mark_we = 1'b1;
						wr.mark_d  = MARK_OCC;
						wr.key_we  = 1'b1;
						wr.val_we  = 1'b1;
						cnt_inc    = 1'b1;
						res_status = ST_OK;
						res_idx    = wr_addr;
					end else begin
						res_status = ST_FULL;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_HOME;
					end
				end
				S_HOME: begin
					if (home_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (fin) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= KEY_BITS'(key);
			val_q  <= VALUE_BITS'(entry_value);
		end
		if ((state_q == S_HOME) && home_done) begin
			idx_q    <= home;
			n_q      <= '0;
			tomb_v_q <= 1'b0;
		end else if (probing && !fin) begin
			idx_q <= idx_nx;
			n_q   <= n_q + 1'b1;
			if (!tomb_v_q && (mark_rd == MARK_TOMB)) begin
				tomb_v_q   <= 1'b1;
				tomb_idx_q <= idx_q;
			end
		end
		if (probing && fin) begin
			status_q <= res_status;
			fval_q   <= res_fval;
			slot_q   <= SLOT_W'(res_idx);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_value = fval_q;
	assign slot        = slot_q;

`ifndef NO_ASSERTIONS
	a_done_from_probe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_PROBE)
		else $error("result strobe without a finished probe");

	a_fill_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FILL_LIMIT)
		else $error("entry count above fill limit");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL || status == ST_MISS) |-> slot == '0 && found_value == '0)
		else $error("full or miss result carries slot or value");

	a_accept_home: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_HOME && !done)
		else $error("accepted request did not start home lookup");
`endif

endmodule
`default_nettype wire

/* sim/linear_probe_hash_table_core_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module linear_probe_hash_table_core_tb;
	import lph_pkg::*;

	localparam int CAP         = DEF_CAPACITY;
	localparam int FILL_LIMIT  = CAP * 3 / 4;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [VALUE_W-1:0] found_value;
		logic [SLOT_W-1:0]  slot;
	} reply_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] entry_value;
		logic [HASH_W-1:0]  hash;
		logic               typed;
		reply_t             reply;
	} stim_row_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [HASH_W-1:0] hash;
	} resident_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [MODE_W-1:0]  mode = '0;
	logic [KEY_W-1:0]   key = '0;
	logic [VALUE_W-1:0] entry_value = '0;
	logic [HASH_W-1:0]  hash = '0;
	logic               busy;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [VALUE_W-1:0] found_value;
	logic [SLOT_W-1:0]  slot;

	mark_t              mark_mirror [CAP];
	logic [KEY_W-1:0]   key_mirror [CAP];
	logic [VALUE_W-1:0] val_mirror [CAP];
	int                 live_count = 0;
	reply_t             pending_replies [$];
	resident_t          residents [$];
	int                 errors = 0;
	int                 cycles = 0;
	bit                 no_idle = 1'b0;
	int                 idle_pct = 30;

	// tombstone reuse, probe wrap, absent remove, unused mode
	stim_row_t directed_rows [0:21] = '{
		'{MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_MISS, 32'h0, 8'h0}},
		'{MODE_REMOVE, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 1'b1, '{ST_MISS, 32'h0, 8'h0}},
		'{MODE_UNUSED, 32'hAAAAAAAA, 32'h55555555, 32'h12345678, 1'b1,
			'{ST_MISS, 32'h0, 8'h0}},
		'{MODE_INSERT, 32'h0, 32'hFFFFFFFF, 32'h0, 1'b1, '{ST_OK, 32'h0, 8'h0}},
		'{MODE_INSERT, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 1'b1, '{ST_OK, 32'h0, 8'hFF}},
		'{MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_OK, 32'hFFFFFFFF, 8'h0}},
		'{MODE_LOOKUP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
			'{ST_OK, 32'h0, 8'hFF}},
		'{MODE_INSERT, 32'hFFFFFFFF, 32'h5555AAAA, 32'h000000FF, 1'b1,
			'{ST_UPDATED, 32'h0, 8'hFF}},
		'{MODE_INSERT, 32'h12345678, 32'h1, 32'hFFFFFFFF, 1'b0, '0},
		'{MODE_LOOKUP, 32'h12345678, 32'h0, 32'h000000FF, 1'b0, '0},
		'{MODE_INSERT, 32'hA5A5A5A5, 32'h2, 32'h00000100, 1'b0, '0},
		'{MODE_REMOVE, 32'h12345678, 32'h0, 32'h000000FF, 1'b0, '0},
		'{MODE_INSERT, 32'hA5A5A5A5, 32'h3, 32'h00000100, 1'b0, '0},
		'{MODE_LOOKUP, 32'hA5A5A5A5, 32'h0, 32'h0, 1'b0, '0},
		'{MODE_INSERT, 32'h5A5A5A5A, 32'h4, 32'h0, 1'b0, '0},
		'{MODE_LOOKUP, 32'h12345678, 32'h0, 32'h000000FF, 1'b0, '0},
		'{MODE_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0, '0},
		'{MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0, '0},
		'{MODE_REMOVE, 32'h0, 32'h0, 32'h0, 1'b0, '0},
		'{MODE_UNUSED, 32'h0, 32'hFFFFFFFF, 32'h0, 1'b1, '{ST_MISS, 32'h0, 8'h0}},
		'{MODE_LOOKUP, 32'h5A5A5A5A, 32'h0, 32'h0, 1'b0, '0},
		'{MODE_INSERT, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, '0}
	};

	linear_probe_hash_table_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.key         (key),
		.entry_value (entry_value),
		.hash        (hash),
		.done        (done),
		.status      (status),
		.found_value (found_value),
		.slot        (slot)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("linear_probe_hash_table_core test failed");
			$finish;
		end
	end

	function automatic int find_key(int home, logic [KEY_W-1:0] k);
		int idx;
		int n;
		idx = home;
		for (n = 0; n < CAP; n++) begin
			if (mark_mirror[idx] == MARK_EMPTY)
				return CAP;
			if (mark_mirror[idx] == MARK_OCC && key_mirror[idx] == k)
				return idx;
			idx = (idx + 1) % CAP;
		end
		return CAP;
	endfunction

	function automatic int first_slot(mark_t m);
		int i;
		for (i = 0; i < CAP; i++)
			if (mark_mirror[i] == m)
				return i;
		return CAP;
	endfunction

	// updates the mirror and returns the reply the request should produce
	function automatic reply_t apply_request(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
			logic [VALUE_W-1:0] v, logic [HASH_W-1:0] h);
		reply_t r;
		int home;
		int idx;
		int p;
		int n;
		int target;
		r.status = ST_MISS;
		r.found_value = '0;
		r.slot = '0;
		home = int'(h % CAP);
		idx = find_key(home, k);
		case (m)
			MODE_LOOKUP: begin
				if (idx < CAP) begin
					r.status = ST_OK;
					r.found_value = val_mirror[idx];
					r.slot = idx[SLOT_W-1:0];
				end
			end
			MODE_INSERT: begin
				if (idx < CAP) begin
					val_mirror[idx] = v;
					r.status = ST_UPDATED;
					r.slot = idx[SLOT_W-1:0];
				end else if (live_count >= FILL_LIMIT) begin
					r.status = ST_FULL;
				end else begin
					p = home;
					target = CAP;
					for (n = 0; n < CAP; n++) begin
						if (mark_mirror[p] != MARK_OCC) begin
							target = p;
							break;
						end
						p = (p + 1) % CAP;
					end
					if (target < CAP) begin
						mark_mirror[target] = MARK_OCC;
						key_mirror[target] = k;
						val_mirror[target] = v;
						live_count++;
						r.status = ST_OK;
						r.slot = target[SLOT_W-1:0];
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			MODE_REMOVE: begin
				if (idx < CAP) begin
					mark_mirror[idx] = MARK_TOMB;
					if (live_count > 0)
						live_count--;
					r.status = ST_OK;
					r.slot = idx[SLOT_W-1:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic issue(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v, input logic [HASH_W-1:0] h, input logic typed,
			input reply_t typed_reply, output reply_t predicted);
		start <= 1'b1;
		mode <= m;
		key <= k;
		entry_value <= v;
		hash <= h;
		do @(posedge clk); while (busy);
		predicted = apply_request(m, k, v, h);
		pending_replies.push_back(typed ? typed_reply : predicted);
		if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic do_op(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v, input logic [HASH_W-1:0] h, output reply_t predicted);
		issue(m, k, v, h, 1'b0, '0, predicted);
	endtask

	// mix of spread hashes and home slots bunched at both ends of the range
	function automatic logic [HASH_W-1:0] pick_hash();
		logic [HASH_W-1:0] h;
		int r;
		h = $urandom();
		r = $urandom_range(0, 9);
		if (r >= 8)
			h[7:0] = 8'($urandom_range(CAP - 8, CAP - 1));
		else if (r >= 5)
			h[7:0] = 8'($urandom_range(0, 7));
		return h;
	endfunction

	task automatic random_op(input int new_pct);
		reply_t p;
		resident_t res;
		logic [KEY_W-1:0] k;
		logic [HASH_W-1:0] h;
		int r;
		int i;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			do_op(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(), p);
		end else if (r < 5 + new_pct || residents.size() == 0) begin
			k = $urandom();
			h = pick_hash();
			do_op(MODE_INSERT, k, $urandom(), h, p);
			if (p.status == ST_OK)
				residents.push_back('{k, h});
		end else begin
			i = $urandom_range(0, residents.size() - 1);
			res = residents[i];
			r = $urandom_range(0, 99);
			if (r < 35) begin
				do_op(MODE_LOOKUP, res.key, $urandom(), res.hash, p);
			end else if (r < 65) begin
				do_op(MODE_INSERT, res.key, $urandom(), res.hash, p);
			end else if (r < 90) begin
				do_op(MODE_REMOVE, res.key, $urandom(), res.hash, p);
				if (p.status == ST_OK)
					residents.delete(i);
			end else begin
				do_op(MODE_LOOKUP, res.key ^ (32'h1 << $urandom_range(0, 31)), $urandom(),
					res.hash, p);
			end
		end
	endtask

	always @(posedge clk) begin : check_result
		reply_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				errors++;
				$display("%0t: result with no request pending: status %0d found_value %h slot %0d",
					$time, status, found_value, slot);
			end else begin
				want = pending_replies.pop_front();
				if (status !== want.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				end
				if (found_value !== want.found_value) begin
					errors++;
					$display("%0t: found_value expected %h actual %h", $time,
						want.found_value, found_value);
				end
				if (slot !== want.slot) begin
					errors++;
					$display("%0t: slot expected %0d actual %0d", $time, want.slot, slot);
				end
			end
		end
	end

	initial begin
		reply_t p;
		logic [KEY_W-1:0] k;
		logic [HASH_W-1:0] h;
		int e;
		int o;
		int i;
		int n;
		for (i = 0; i < CAP; i++) begin
			mark_mirror[i] = MARK_EMPTY;
			key_mirror[i] = '0;
			val_mirror[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			issue(directed_rows[r].mode, directed_rows[r].key, directed_rows[r].entry_value,
				directed_rows[r].hash, directed_rows[r].typed, directed_rows[r].reply, p);

		// light load, probe chains and wrap
		for (n = 0; n < 700; n++) begin
			if (n % 100 == 0)
				idle_pct = 25 * $urandom_range(0, 2);
			random_op(25);
		end

		// fill to the load limit, then churn against it
		idle_pct = 25;
		while (live_count < FILL_LIMIT) begin
			k = $urandom();
			h = pick_hash();
			do_op(MODE_INSERT, k, $urandom(), h, p);
			if (p.status == ST_OK)
				residents.push_back('{k, h});
		end
		for (n = 0; n < 150; n++)
			random_op(30);

		// use up every empty slot so misses run a full pass
		e = first_slot(MARK_EMPTY);
		while (e < CAP) begin
			h = $urandom();
			if (live_count < FILL_LIMIT) begin
				k = $urandom();
				h[7:0] = e[7:0];
				do_op(MODE_INSERT, k, $urandom(), h, p);
				residents.push_back('{k, h});
			end else begin
				o = first_slot(MARK_OCC);
				k = key_mirror[o];
				h[7:0] = o[7:0];
				do_op(MODE_REMOVE, k, $urandom(), h, p);
				for (i = 0; i < residents.size(); i++)
					if (residents[i].key == k) begin
						residents.delete(i);
						break;
					end
			end
			e = first_slot(MARK_EMPTY);
		end

		no_idle = 1'b1;
		for (n = 0; n < 80; n++)
			random_op(30);

		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (CAP + 16) @(posedge clk);
		if (errors == 0)
			$display("linear_probe_hash_table_core test passed");
		else
			$display("linear_probe_hash_table_core test failed");
		$finish;
	end

endmodule
`default_nettype wire
